>>> rtl/core/tsca_pkg.sv
package tsca_pkg;

	localparam int IdW   = 32;
	localparam int PrioW = 8;
	localparam int CntW  = 32;

	localparam logic [2:0] MODE_SUBMIT    = 3'd0;
	localparam logic [2:0] MODE_CANCEL    = 3'd1;
	localparam logic [2:0] MODE_POLL      = 3'd2;
	localparam logic [2:0] MODE_START_OUT = 3'd3;
	localparam logic [2:0] MODE_STOP_OUT  = 3'd4;

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_STARTING   = 3'd1;
	localparam logic [2:0] ST_ACTIVE     = 3'd2;
	localparam logic [2:0] ST_FINISHING  = 3'd3;
	localparam logic [2:0] ST_PREEMPTING = 3'd4;
	localparam logic [2:0] ST_ERROR      = 3'd5;

	localparam logic [1:0] REC_IDLE       = 2'd0;
	localparam logic [1:0] REC_RECORDING  = 2'd1;
	localparam logic [1:0] REC_PROCESSING = 2'd2;

	localparam logic [1:0] CALL_OK            = 2'd0;
	localparam logic [1:0] CALL_INVALID_STATE = 2'd1;

	localparam logic [1:0] RC_OK            = 2'd0;
	localparam logic [1:0] RC_INVALID_STATE = 2'd1;
	localparam logic [1:0] RC_INVALID_ARG   = 2'd2;
	localparam logic [1:0] RC_NOT_FOUND     = 2'd3;

	localparam logic [1:0] RULE_REJECT  = 2'd0;
	localparam logic [1:0] RULE_QUEUE   = 2'd1;
	localparam logic [1:0] RULE_PREEMPT = 2'd2;

	localparam logic [1:0] ERR_OK            = 2'd0;
	localparam logic [1:0] ERR_INVALID_STATE = 2'd1;
	localparam logic [1:0] ERR_FAILURE       = 2'd2;

	typedef struct packed {
		logic [2:0]       mode;
		logic [IdW-1:0]   req_id;
		logic [PrioW-1:0] req_priority;
		logic [1:0]       busy_rule;
		logic             req_interruptible;
		logic             req_acceptable;
		logic [1:0]       recorder_state;
		logic [1:0]       call_status;
	} tsca_in_t;

	typedef struct packed {
		logic [1:0]      result_code;
		logic            start_cmd;
		logic            stop_cmd;
		logic [2:0]      arb_state;
		logic            cur_valid;
		logic            pend_valid;
		logic [IdW-1:0]  cur_id_out;
		logic [IdW-1:0]  pend_id_out;
		logic [1:0]      last_err;
		logic [CntW-1:0] done_count;
		logic [CntW-1:0] preempted_count;
		logic [CntW-1:0] fail_count;
	} tsca_out_t;

	typedef struct packed {
		logic [IdW-1:0]   cur_id;
		logic [PrioW-1:0] cur_prio;
		logic             cur_intr;
		logic             cur_v;
		logic [IdW-1:0]   pend_id;
		logic [PrioW-1:0] pend_prio;
		logic             pend_intr;
		logic             pend_v;
		logic             cancel_f;
		logic             preempt_f;
		logic             seen_rec;
		logic [2:0]       arb_st;
		logic [1:0]       err;
		logic [CntW-1:0]  done_ctr;
		logic [CntW-1:0]  preempt_ctr;
		logic [CntW-1:0]  fail_ctr;
	} tsca_state_t;

	function automatic tsca_state_t promote(input tsca_state_t s);
		tsca_state_t r;
		r = s;
		if (s.pend_v) begin
			r.cur_id    = s.pend_id;
			r.cur_prio  = s.pend_prio;
			r.cur_intr  = s.pend_intr;
			r.cur_v     = 1'b1;
			r.pend_id   = '0;
			r.pend_prio = '0;
			r.pend_intr = 1'b0;
			r.pend_v    = 1'b0;
			r.seen_rec  = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tsca_if.sv
interface tsca_req_if;
	import tsca_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [2:0]             mode;
	logic [IdW-1:0]         req_id;
	logic [PrioW-1:0]       req_priority;
	logic [1:0]             busy_rule;
	logic                   req_interruptible;
	logic                   req_acceptable;
	logic [1:0]             recorder_state;
	logic [1:0]             call_status;

	modport source(output valid, mode, req_id, req_priority, busy_rule, req_interruptible,
		req_acceptable, recorder_state, call_status, input ready);
	modport sink(input valid, mode, req_id, req_priority, busy_rule, req_interruptible,
		req_acceptable, recorder_state, call_status, output ready);
endinterface

interface tsca_rsp_if;
	import tsca_pkg::*;

	logic            valid;
	logic            ready;
	logic [1:0]      result_code;
	logic            start_cmd;
	logic            stop_cmd;
	logic [2:0]      arb_state;
	logic            cur_valid;
	logic            pend_valid;
	logic [IdW-1:0]  cur_id_out;
	logic [IdW-1:0]  pend_id_out;
	logic [1:0]      last_err;
	logic [CntW-1:0] done_count;
	logic [CntW-1:0] preempted_count;
	logic [CntW-1:0] fail_count;

	modport source(output valid, result_code, start_cmd, stop_cmd, arb_state, cur_valid,
		pend_valid, cur_id_out, pend_id_out, last_err, done_count, preempted_count,
		fail_count, input ready);
	modport sink(input valid, result_code, start_cmd, stop_cmd, arb_state, cur_valid,
		pend_valid, cur_id_out, pend_id_out, last_err, done_count, preempted_count,
		fail_count, output ready);
endinterface

>>> rtl/core/tsca_step.sv
module tsca_step (
	input  tsca_pkg::tsca_state_t cur_state,
	input  tsca_pkg::tsca_in_t    item,
	output tsca_pkg::tsca_state_t next_state,
	output tsca_pkg::tsca_out_t   result
);
	import tsca_pkg::*;

	tsca_state_t n;
	logic [1:0]  rc;
	logic        start_c;
	logic        stop_c;

	always_comb begin
		n       = cur_state;
		rc      = RC_OK;
		start_c = 1'b0;
		stop_c  = 1'b0;
		case (item.mode)
			MODE_SUBMIT: begin
				if (!item.req_acceptable) begin
					rc = RC_INVALID_ARG;
				end else if ((n.cur_v && n.cur_id == item.req_id) ||
					(n.pend_v && n.pend_id == item.req_id)) begin
					rc = RC_INVALID_STATE;
				end else if (!n.cur_v) begin
					n.cur_id   = item.req_id;
					n.cur_prio = item.req_priority;
					n.cur_intr = item.req_interruptible;
					n.cur_v    = 1'b1;
					n.seen_rec = 1'b0;
					n.arb_st   = ST_IDLE;
					n.err      = ERR_OK;
				end else if (item.busy_rule == RULE_QUEUE) begin
					if (!n.pend_v) begin
						n.pend_id   = item.req_id;
						n.pend_prio = item.req_priority;
						n.pend_intr = item.req_interruptible;
						n.pend_v    = 1'b1;
					end else begin
						rc = RC_INVALID_STATE;
					end
				end else if (item.busy_rule == RULE_PREEMPT) begin
					if (!n.pend_v && n.cur_intr && item.req_priority > n.cur_prio) begin
						n.pend_id   = item.req_id;
						n.pend_prio = item.req_priority;
						n.pend_intr = item.req_interruptible;
						n.pend_v    = 1'b1;
						n.preempt_f = 1'b1;
					end else begin
						rc = RC_INVALID_STATE;
					end
				end else if (item.busy_rule == RULE_REJECT) begin
					rc = RC_INVALID_STATE;
				end else begin
					rc = RC_INVALID_ARG;
				end
			end
			MODE_CANCEL: begin
				if (item.req_id == '0) begin
					rc = RC_INVALID_ARG;
				end else if (n.pend_v && n.pend_id == item.req_id) begin
					n.pend_id   = '0;
					n.pend_prio = '0;
					n.pend_intr = 1'b0;
					n.pend_v    = 1'b0;
					n.err       = ERR_OK;
				end else if (n.cur_v && n.cur_id == item.req_id) begin
					n.cancel_f = 1'b1;
					n.err      = ERR_OK;
				end else begin
					rc = RC_NOT_FOUND;
				end
			end
			MODE_POLL: begin
				if (item.call_status != CALL_OK) begin
					n.arb_st   = ST_ERROR;
					n.err      = (item.call_status == CALL_INVALID_STATE) ?
						ERR_INVALID_STATE : ERR_FAILURE;
					n.fail_ctr = n.fail_ctr + CntW'(1);
				end else begin
					if (n.cur_v) begin
						if (item.recorder_state == REC_RECORDING) begin
							n.seen_rec = 1'b1;
							if (n.cancel_f || n.preempt_f) begin
								stop_c   = 1'b1;
								n.arb_st = ST_PREEMPTING;
							end else begin
								n.arb_st = ST_ACTIVE;
							end
							n.err = ERR_OK;
						end else if (n.seen_rec && item.recorder_state == REC_PROCESSING) begin
							n.arb_st = ST_FINISHING;
							n.err    = ERR_OK;
						end else if (n.seen_rec && item.recorder_state == REC_IDLE) begin
							if (n.preempt_f) begin
								n.preempt_ctr = n.preempt_ctr + CntW'(1);
							end else if (!n.cancel_f) begin
								n.done_ctr = n.done_ctr + CntW'(1);
							end
							n.cur_id    = '0;
							n.cur_prio  = '0;
							n.cur_intr  = 1'b0;
							n.cur_v     = 1'b0;
							n.cancel_f  = 1'b0;
							n.preempt_f = 1'b0;
							n.seen_rec  = 1'b0;
							n           = promote(n);
							n.arb_st    = ST_IDLE;
							n.err       = ERR_OK;
						end
					end
					if (!n.cur_v && n.pend_v && item.recorder_state == REC_IDLE) begin
						n = promote(n);
					end
					if (n.cur_v && !n.seen_rec && item.recorder_state == REC_IDLE &&
						!n.cancel_f && !n.preempt_f && n.arb_st != ST_STARTING) begin
						start_c  = 1'b1;
						n.arb_st = ST_STARTING;
						n.err    = ERR_OK;
					end
					if (!n.cur_v && !n.pend_v && item.recorder_state == REC_IDLE) begin
						n.arb_st = ST_IDLE;
						n.err    = ERR_OK;
					end
				end
			end
			MODE_START_OUT: begin
				if (item.call_status == CALL_OK) begin
					n.arb_st = ST_STARTING;
					n.err    = ERR_OK;
				end else if (item.call_status == CALL_INVALID_STATE) begin
					n.arb_st = ST_IDLE;
					n.err    = ERR_INVALID_STATE;
				end else begin
					n.fail_ctr = n.fail_ctr + CntW'(1);
					n.cur_id   = '0;
					n.cur_prio = '0;
					n.cur_intr = 1'b0;
					n.cur_v    = 1'b0;
					n.seen_rec = 1'b0;
					n          = promote(n);
					n.arb_st   = ST_ERROR;
					n.err      = ERR_FAILURE;
				end
			end
			MODE_STOP_OUT: begin
				if (item.call_status != CALL_OK && item.call_status != CALL_INVALID_STATE) begin
					n.arb_st   = ST_ERROR;
					n.err      = ERR_FAILURE;
					n.fail_ctr = n.fail_ctr + CntW'(1);
				end
			end
			default: begin
				rc = RC_INVALID_ARG;
			end
		endcase
	end

	assign next_state = n;

	assign result.result_code     = rc;
	assign result.start_cmd       = start_c;
	assign result.stop_cmd        = stop_c;
	assign result.arb_state       = n.arb_st;
	assign result.cur_valid       = n.cur_v;
	assign result.pend_valid      = n.pend_v;
	assign result.cur_id_out      = n.cur_v ? n.cur_id : '0;
	assign result.pend_id_out     = n.pend_v ? n.pend_id : '0;
	assign result.last_err        = n.err;
	assign result.done_count      = n.done_ctr;
	assign result.preempted_count = n.preempt_ctr;
	assign result.fail_count      = n.fail_ctr;

endmodule

>>> rtl/core/tsca_outreg.sv
module tsca_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tsca_pkg::tsca_out_t load_data,
	output logic                space,
	input  logic                out_ready,
	output logic                out_valid,
	output tsca_pkg::tsca_out_t out_data
);
	import tsca_pkg::*;

	logic      valid_q;
	tsca_out_t data_q;

	assign space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> rtl/core/two_slot_capture_arbiter.sv
// Arbiter for one capture resource with a current and a pending request slot.
// Events arrive as beats on the req channel: submit, cancel, recorder poll, and
// the outcomes of start and stop calls, selected by the mode field. Every event
// beat produces exactly one result beat on the rsp channel, in order, holding the
// result code, the start and stop commands raised by a poll, and a snapshot of the
// arbiter state, both slots, the last error and the three wrapping counters.
// An accepted beat is held in an input register; the state update and the result
// are computed from that register and written into the output register, so a
// result passes the input register and then the output register before it is offered.
// One event per cycle is sustained while rsp is ready; the state register is fed back
// through the combinational event logic.
// When the receiver stalls, the result stays in the output register, the event
// behind it waits in the input register, and req.ready falls until rsp moves.
// The state only changes when an event moves into the output register.
// Reset empties both slots, clears the flags and counters, sets the state to idle
// and the last error to ok, and discards any beat in flight.
module two_slot_capture_arbiter (
	input  logic              clk,
	input  logic              arst_n,
	tsca_req_if.sink          req,
	tsca_rsp_if.source        rsp
);
	import tsca_pkg::*;

	logic        v_s1;
	tsca_in_t    item_s1;
	tsca_in_t    req_item;
	tsca_state_t st_q;
	tsca_state_t st_next;
	tsca_out_t   res;
	tsca_out_t   rsp_data;
	logic        space;
	logic        adv;

	assign req_item.mode              = req.mode;
	assign req_item.req_id            = req.req_id;
	assign req_item.req_priority      = req.req_priority;
	assign req_item.busy_rule         = req.busy_rule;
	assign req_item.req_interruptible = req.req_interruptible;
	assign req_item.req_acceptable    = req.req_acceptable;
	assign req_item.recorder_state    = req.recorder_state;
	assign req_item.call_status       = req.call_status;

	assign adv       = v_s1 && space;
	assign req.ready = !v_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	tsca_step u_step (
		.cur_state  (st_q),
		.item       (item_s1),
		.next_state (st_next),
		.result     (res)
	);

	tsca_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (v_s1),
		.load_data (res),
		.space     (space),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp_data)
	);

	assign rsp.result_code     = rsp_data.result_code;
	assign rsp.start_cmd       = rsp_data.start_cmd;
	assign rsp.stop_cmd        = rsp_data.stop_cmd;
	assign rsp.arb_state       = rsp_data.arb_state;
	assign rsp.cur_valid       = rsp_data.cur_valid;
	assign rsp.pend_valid      = rsp_data.pend_valid;
	assign rsp.cur_id_out      = rsp_data.cur_id_out;
	assign rsp.pend_id_out     = rsp_data.pend_id_out;
	assign rsp.last_err        = rsp_data.last_err;
	assign rsp.done_count      = rsp_data.done_count;
	assign rsp.preempted_count = rsp_data.preempted_count;
	assign rsp.fail_count      = rsp_data.fail_count;

	a_pend_needs_cur: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pend_v |-> st_q.cur_v)
		else $error("pending slot occupied while current slot is empty");

	a_empty_cur_id: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.cur_v |-> st_q.cur_id == '0)
		else $error("empty current slot holds a nonzero id");

	a_empty_pend_id: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.pend_v |-> st_q.pend_id == '0)
		else $error("empty pending slot holds a nonzero id");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(st_q))
		else $error("arbiter state changed while the result was stalled");

endmodule
